// ===== rtl/mbsp_pkg.sv =====
`timescale 1ns / 1ps

package mbsp_pkg;

   // result kinds
   localparam logic [1:0] KIND_CHANNEL    = 2'd0;
   localparam logic [1:0] KIND_SYSEX_BYTE = 2'd1;
   localparam logic [1:0] KIND_SYSEX_END  = 2'd2;
   localparam logic [1:0] KIND_ERROR      = 2'd3;

   // status bytes of interest
   localparam logic [7:0] BYTE_TIMING_CLOCK   = 8'hF8;
   localparam logic [7:0] BYTE_ACTIVE_SENSING = 8'hFE;
   localparam logic [7:0] BYTE_SYSEX_START    = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END      = 8'hF7;
   localparam logic [3:0] NIBBLE_PROGRAM      = 4'hC;
   localparam logic [3:0] NIBBLE_PRESSURE     = 4'hD;
   localparam logic [3:0] NIBBLE_SYSTEM       = 4'hF;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // parser state carried from item to item
   typedef struct packed {
      logic [7:0]  running_status;
      logic [1:0]  bytes_expected;
      logic [1:0]  bytes_left;
      logic [6:0]  held_first_data;
      logic        in_sysex;
      logic [15:0] sysex_count;
      logic [6:0]  slot_pointer;
      logic [31:0] held_stamp;
      logic        stamp_taken;
   } state_type;

   // one result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  status_byte;
      logic [6:0]  first_data;
      logic [6:0]  second_data;
      logic [6:0]  sysex_slot;
      logic [7:0]  sysex_data;
      logic [15:0] sysex_position;
      logic [31:0] msg_stamp;
   } result_type;

endpackage

// ===== rtl/mbsp_decode.sv =====
`timescale 1ns / 1ps

module mbsp_decode #(
   parameter int SYSEX_SLOTS = 128
) (
   input  mbsp_pkg::state_type  state_cur,
   input  logic [7:0]           rx_byte,
   input  logic [31:0]          now_stamp,
   input  logic                 paused,
   output mbsp_pkg::state_type  state_nxt,
   output logic                 emit,
   output mbsp_pkg::result_type result
);

   localparam logic [8:0] SLOT_LIMIT = 9'(SYSEX_SLOTS);

   logic [15:0] count_inc;
   logic [8:0]  slot_wide;
   logic [6:0]  slot_adv;
   logic [31:0] first_stamp;
   logic        one_byte_msg;

   // saturating sysex count and cyclic slot pointer
   always_comb begin
      count_inc   = (state_cur.sysex_count == mbsp_pkg::COUNT_MAX) ?
                    mbsp_pkg::COUNT_MAX : state_cur.sysex_count + 16'd1;
      slot_wide   = {2'b00, state_cur.slot_pointer} + 9'd1;
      slot_adv    = (slot_wide >= SLOT_LIMIT) ? 7'd0 : slot_wide[6:0];
      first_stamp = state_cur.stamp_taken ? state_cur.held_stamp : now_stamp;
      one_byte_msg = (rx_byte[7:4] == mbsp_pkg::NIBBLE_PROGRAM) ||
                     (rx_byte[7:4] == mbsp_pkg::NIBBLE_PRESSURE);
   end

   // next state and result for one byte
   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      result    = '0;
      if (rx_byte == mbsp_pkg::BYTE_TIMING_CLOCK ||
          rx_byte == mbsp_pkg::BYTE_ACTIVE_SENSING) begin
         // real-time bytes are dropped
      end else if (rx_byte[7]) begin
         if (rx_byte == mbsp_pkg::BYTE_SYSEX_START) begin
            if (!state_cur.in_sysex) begin
               state_nxt.bytes_expected = 2'd0;
               state_nxt.bytes_left     = 2'd0;
               state_nxt.running_status = 8'd0;
               state_nxt.stamp_taken    = 1'b0;
               state_nxt.in_sysex       = 1'b1;
               state_nxt.sysex_count    = 16'd1;
               emit                     = !paused;
               result.kind              = mbsp_pkg::KIND_SYSEX_BYTE;
               result.status_byte       = mbsp_pkg::BYTE_SYSEX_START;
               result.sysex_slot        = state_cur.slot_pointer;
               result.sysex_data        = mbsp_pkg::BYTE_SYSEX_START;
               result.msg_stamp         = now_stamp;
            end
         end else if (rx_byte == mbsp_pkg::BYTE_SYSEX_END) begin
            if (state_cur.in_sysex) begin
               state_nxt.in_sysex    = 1'b0;
               state_nxt.sysex_count = 16'd0;
               emit                  = !paused;
               if (!paused) begin
                  state_nxt.slot_pointer = slot_adv;
               end
               result.kind           = mbsp_pkg::KIND_SYSEX_END;
               result.status_byte    = mbsp_pkg::BYTE_SYSEX_START;
               result.sysex_slot     = state_cur.slot_pointer;
               result.sysex_data     = mbsp_pkg::BYTE_SYSEX_END;
               result.sysex_position = count_inc;
               result.msg_stamp      = now_stamp;
            end
         end else if (rx_byte[7:4] == mbsp_pkg::NIBBLE_SYSTEM) begin
            // other system bytes cancel running status outside a sysex
            if (!state_cur.in_sysex) begin
               state_nxt.bytes_expected = 2'd0;
               state_nxt.bytes_left     = 2'd0;
               state_nxt.running_status = 8'd0;
               state_nxt.stamp_taken    = 1'b0;
            end
         end else begin
            // channel status; aborts an open sysex with an error item
            if (state_cur.in_sysex) begin
               emit                  = !paused;
               result.kind           = mbsp_pkg::KIND_ERROR;
               result.status_byte    = rx_byte;
               result.sysex_slot     = state_cur.slot_pointer;
               result.sysex_position = state_cur.sysex_count;
               result.msg_stamp      = now_stamp;
               state_nxt.in_sysex    = 1'b0;
               state_nxt.sysex_count = 16'd0;
            end
            state_nxt.running_status  = rx_byte;
            state_nxt.bytes_expected  = one_byte_msg ? 2'd1 : 2'd2;
            state_nxt.bytes_left      = one_byte_msg ? 2'd1 : 2'd2;
            state_nxt.held_first_data = 7'd0;
            state_nxt.held_stamp      = now_stamp;
            state_nxt.stamp_taken     = 1'b1;
         end
      end else if (state_cur.in_sysex) begin
         // sysex data byte passed through
         emit                  = !paused;
         result.kind           = mbsp_pkg::KIND_SYSEX_BYTE;
         result.status_byte    = mbsp_pkg::BYTE_SYSEX_START;
         result.sysex_slot     = state_cur.slot_pointer;
         result.sysex_data     = rx_byte;
         result.sysex_position = state_cur.sysex_count;
         result.msg_stamp      = now_stamp;
         state_nxt.sysex_count = count_inc;
      end else if (state_cur.bytes_left != 2'd0) begin
         // channel data byte
         state_nxt.held_stamp  = first_stamp;
         state_nxt.stamp_taken = 1'b1;
         result.kind           = mbsp_pkg::KIND_CHANNEL;
         result.status_byte    = state_cur.running_status;
         result.msg_stamp      = first_stamp;
         if (state_cur.bytes_left == state_cur.bytes_expected) begin
            state_nxt.held_first_data = rx_byte[6:0];
            state_nxt.bytes_left      = state_cur.bytes_left - 2'd1;
            result.first_data         = rx_byte[6:0];
            if (state_cur.bytes_left == 2'd1) begin
               emit                  = !paused;
               state_nxt.bytes_left  = state_cur.bytes_expected;
               state_nxt.stamp_taken = 1'b0;
            end
         end else begin
            emit                  = !paused;
            result.first_data     = state_cur.held_first_data;
            result.second_data    = rx_byte[6:0];
            state_nxt.bytes_left  = state_cur.bytes_expected;
            state_nxt.stamp_taken = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/midi_byte_stream_parser.sv =====
`timescale 1ns / 1ps

// MIDI byte parser: one received byte with its timer stamp per item. Items
// pass an input register and a result register, so one item is taken per
// clock unless a stalled result holds the input register; the result (if
// any) is set by the single decode stage between the registers and held
// in the result register until it is taken. Timing clock
// and active sensing are dropped, channel messages are assembled with
// running status, sysex bytes are passed out with position and slot, and a
// channel status inside a sysex gives an error item. Writing paused = 1
// (only while idle) suppresses all result items; parsing still goes on.
module midi_byte_stream_parser #(
   parameter int SYSEX_SLOTS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_now_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_first_data,
   output logic [6:0]  rsp_second_data,
   output logic [6:0]  rsp_sysex_slot,
   output logic [7:0]  rsp_sysex_data,
   output logic [15:0] rsp_sysex_position,
   output logic [31:0] rsp_msg_stamp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_paused
);

   logic                 paused_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic [31:0]          in_stamp_ff;
   mbsp_pkg::state_type  state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mbsp_pkg::result_type rsp_ff;
   mbsp_pkg::result_type result;
   logic                 emit;
   logic                 advance;
   logic                 accept;

   // handshake
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (advance && emit);
   assign csr_ready   = 1'b1;

   mbsp_decode #(
      .SYSEX_SLOTS(SYSEX_SLOTS)
   ) u_decode (
      .state_cur(state_ff),
      .rx_byte  (in_byte_ff),
      .now_stamp(in_stamp_ff),
      .paused   (paused_ff),
      .state_nxt(state_in),
      .emit     (emit),
      .result   (result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            paused_ff <= csr_paused;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_rx_byte;
         in_stamp_ff <= req_now_stamp;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_status_byte    = rsp_ff.status_byte;
   assign rsp_first_data     = rsp_ff.first_data;
   assign rsp_second_data    = rsp_ff.second_data;
   assign rsp_sysex_slot     = rsp_ff.sysex_slot;
   assign rsp_sysex_data     = rsp_ff.sysex_data;
   assign rsp_sysex_position = rsp_ff.sysex_position;
   assign rsp_msg_stamp      = rsp_ff.msg_stamp;

   // data byte count never exceeds the message length
   assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_left <= state_ff.bytes_expected)
      else $error("bytes_left above bytes_expected");

   // an open sysex leaves no channel message pending
   assert property (@(posedge clock) disable iff (reset)
      state_ff.in_sysex |-> (state_ff.bytes_left == 2'd0 &&
                             state_ff.running_status == 8'd0))
      else $error("channel state live inside sysex");

   // channel messages carry a channel status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == mbsp_pkg::KIND_CHANNEL) |->
      (rsp_ff.status_byte[7] && rsp_ff.status_byte[7:4] != mbsp_pkg::NIBBLE_SYSTEM))
      else $error("channel item without channel status");

   // a held result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("decode advanced over stalled result");

endmodule
